[design/bhm_pkg.sv]
// Shared types and constants for the bucketed hash map.
// No dependencies; used by every module in this folder.
package bhm_pkg;

   localparam int DEF_NUM_BUCKETS  = 1024;
   localparam int DEF_BUCKET_SLOTS = 4;

   localparam int MODE_W = 2;
   localparam int KEY_W  = 31;
   localparam int VAL_W  = 31;

   localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // Remainder unit: key padded to MOD_STEPS digits of MOD_DIGIT_W bits
   localparam int MOD_DIGIT_W = 4;
   localparam int MOD_STEPS   = 8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_CNT,
      ST_SCAN,
      ST_CMP,
      ST_ACT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic mod_step;
      logic clr_step;
      logic cnt_rd;
      logic slot_rd;
      logic shift_rd;
      logic set_found;
      logic idx_inc;
      logic put_wr;
      logic shift_wr;
      logic cnt_wr;
      logic cnt_inc;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic              clr_done;
      logic              mod_done;
      logic              scan_end;
      logic              key_match;
      logic              found;
      logic              full;
      logic              last_slot;
      logic              shift_last;
      logic              rsp_free;
      logic [MODE_W-1:0] mode;
   } sts_type;

endpackage

[design/bhm_mod.sv]
// Bucket index unit: key modulo NUM_BUCKETS.
// Power-of-two bucket counts take the low bits; others run a restoring
// remainder, one digit per cycle. Depends on bhm_pkg.
module bhm_mod #(
   parameter int NUM_BUCKETS = bhm_pkg::DEF_NUM_BUCKETS
) (
   input  logic                      clock,
   input  logic                      start,
   input  logic                      step,
   input  logic [bhm_pkg::KEY_W-1:0] key,
   output logic [$clog2(NUM_BUCKETS)-1:0] bucket,
   output logic                      done
);

   localparam int BW      = $clog2(NUM_BUCKETS);
   localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic [bhm_pkg::KEY_W-1:0] key_ff, key_in;
         logic [BW-1:0]             bucket_ff, bucket_in;

         always_comb begin
            key_in    = start ? key : key_ff;
            bucket_in = step ? key_ff[BW-1:0] : bucket_ff;
         end

         always_ff @(posedge clock) begin
            key_ff    <= key_in;
            bucket_ff <= bucket_in;
         end

         assign bucket = bucket_ff;
         assign done   = 1'b1;
      end else begin : g_rem
         localparam int SH_W  = bhm_pkg::MOD_STEPS * bhm_pkg::MOD_DIGIT_W;
         localparam int CNT_W = $clog2(bhm_pkg::MOD_STEPS);
         localparam logic [BW:0]      NB_X = (BW + 1)'(NUM_BUCKETS);
         localparam logic [CNT_W-1:0] LAST = CNT_W'(bhm_pkg::MOD_STEPS - 1);

         logic [SH_W-1:0]  sh_ff, sh_in;
         logic [BW-1:0]    rem_ff, rem_in, rem_next, t;
         logic [BW:0]      x;
         logic [CNT_W-1:0] cnt_ff, cnt_in;

         // one digit: shift in a bit at a time, subtract when over
         always_comb begin
            t = rem_ff;
            x = '0;
            for (int k = 0; k < bhm_pkg::MOD_DIGIT_W; k++) begin
               x = {t, sh_ff[SH_W-1-k]};
               if (x >= NB_X) begin
                  x = x - NB_X;
               end
               t = x[BW-1:0];
            end
            rem_next = t;
         end

         always_comb begin
            sh_in  = sh_ff;
            rem_in = rem_ff;
            cnt_in = cnt_ff;
            if (start) begin
               sh_in  = SH_W'(key);
               rem_in = '0;
               cnt_in = '0;
            end else if (step) begin
               sh_in  = sh_ff << bhm_pkg::MOD_DIGIT_W;
               rem_in = rem_next;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         always_ff @(posedge clock) begin
            sh_ff  <= sh_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_in;
         end

         assign bucket = rem_ff;
         assign done   = (cnt_ff == LAST);
      end
   endgenerate

endmodule

[design/bhm_dpath.sv]
// Datapath: request registers, slot and count memories, scan index,
// result register. Depends on bhm_pkg and bhm_mod.
module bhm_dpath #(
   parameter int NUM_BUCKETS  = bhm_pkg::DEF_NUM_BUCKETS,
   parameter int BUCKET_SLOTS = bhm_pkg::DEF_BUCKET_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bhm_pkg::cmd_type           cmd,
   output bhm_pkg::sts_type           sts,
   input  logic [bhm_pkg::MODE_W-1:0] req_mode,
   input  logic [bhm_pkg::KEY_W-1:0]  req_key,
   input  logic [bhm_pkg::VAL_W-1:0]  req_value,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [bhm_pkg::VAL_W-1:0]  rsp_read_value,
   output logic                       rsp_found,
   output logic                       rsp_dropped
);

   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int CW    = $clog2(BUCKET_SLOTS + 1);
   localparam int DEPTH = NUM_BUCKETS * BUCKET_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] SLOTS_A   = AW'(BUCKET_SLOTS);
   localparam logic [CW-1:0] SLOTS_C   = CW'(BUCKET_SLOTS);
   localparam logic [BW-1:0] LAST_BKT  = BW'(NUM_BUCKETS - 1);

   logic [bhm_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [bhm_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [bhm_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic                       found_ff, found_in;
   logic [BW-1:0]              clr_ff, clr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bhm_pkg::VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic                       rsp_dropped_ff, rsp_dropped_in;

   logic [bhm_pkg::KEY_W-1:0]  key_mem [DEPTH];
   logic [bhm_pkg::VAL_W-1:0]  val_mem [DEPTH];
   logic [CW-1:0]              cnt_mem [NUM_BUCKETS];
   logic [bhm_pkg::KEY_W-1:0]  key_rd_ff;
   logic [bhm_pkg::VAL_W-1:0]  val_rd_ff;
   logic [CW-1:0]              cnt_rd_ff;

   logic [BW-1:0]              bucket;
   logic                       mod_done;
   logic [AW-1:0]              base, slot_addr, next_addr, rd_addr;
   logic [bhm_pkg::KEY_W-1:0]  wr_key;
   logic [bhm_pkg::VAL_W-1:0]  wr_val;
   logic                       cnt_we;
   logic [BW-1:0]              cnt_waddr;
   logic [CW-1:0]              cnt_wdata;
   logic                       mode_ok;

   bhm_mod #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_mod (
      .clock  (clock),
      .start  (cmd.accept),
      .step   (cmd.mod_step),
      .key    (req_key),
      .bucket (bucket),
      .done   (mod_done)
   );

   assign base      = AW'(bucket) * SLOTS_A;
   assign slot_addr = base + AW'(idx_ff);
   assign next_addr = slot_addr + AW'(1);
   assign rd_addr   = cmd.shift_rd ? next_addr : slot_addr;
   // a shift moves the slot just read one place down
   assign wr_key    = cmd.shift_wr ? key_rd_ff : key_ff;
   assign wr_val    = cmd.shift_wr ? val_rd_ff : value_ff;

   always_ff @(posedge clock) begin
      if (cmd.put_wr || cmd.shift_wr) begin
         key_mem[slot_addr] <= wr_key;
         val_mem[slot_addr] <= wr_val;
      end
      if (cmd.slot_rd || cmd.shift_rd) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
      end
   end

   assign cnt_we    = cmd.clr_step || cmd.cnt_wr;
   assign cnt_waddr = cmd.clr_step ? clr_ff : bucket;
   assign cnt_wdata = cmd.clr_step ? '0 :
                      (cmd.cnt_inc ? cnt_rd_ff + CW'(1) : cnt_rd_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.cnt_rd) begin
         cnt_rd_ff <= cnt_mem[bucket];
      end
   end

   assign mode_ok = (mode_ff == bhm_pkg::MODE_PUT) || (mode_ff == bhm_pkg::MODE_GET) ||
                    (mode_ff == bhm_pkg::MODE_REMOVE);

   always_comb begin
      mode_in        = mode_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      clr_in         = clr_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         mode_in  = req_mode;
         key_in   = req_key;
         value_in = req_value;
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + BW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = (mode_ff == bhm_pkg::MODE_GET && found_ff) ? val_rd_ff : '0;
         rsp_found_in   = found_ff && mode_ok;
         rsp_dropped_in = (mode_ff == bhm_pkg::MODE_PUT) && !found_ff &&
                          (cnt_rd_ff == SLOTS_C);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_comb begin
      sts.clr_done   = (clr_ff == LAST_BKT);
      sts.mod_done   = mod_done;
      sts.scan_end   = (idx_ff >= cnt_rd_ff);
      sts.key_match  = (key_rd_ff == key_ff);
      sts.found      = found_ff;
      sts.full       = (cnt_rd_ff == SLOTS_C);
      sts.last_slot  = ({1'b0, idx_ff} + (CW + 1)'(1)) >= {1'b0, cnt_rd_ff};
      sts.shift_last = ({1'b0, idx_ff} + (CW + 1)'(2)) >= {1'b0, cnt_rd_ff};
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
      sts.mode       = mode_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_dropped    = rsp_dropped_ff;

endmodule

[design/bhm_ctrl.sv]
// Controller: sequences clear pass, bucket index, scan, update and result.
// Depends on bhm_pkg.
module bhm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bhm_pkg::sts_type sts,
   output bhm_pkg::cmd_type cmd
);

   bhm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bhm_pkg::ST_CLEAR: begin
            if (sts.clr_done) state_in = bhm_pkg::ST_IDLE;
         end
         bhm_pkg::ST_IDLE: begin
            if (req_valid) state_in = bhm_pkg::ST_MOD;
         end
         bhm_pkg::ST_MOD: begin
            if (sts.mod_done) state_in = bhm_pkg::ST_CNT;
         end
         bhm_pkg::ST_CNT: begin
            state_in = bhm_pkg::ST_SCAN;
         end
         bhm_pkg::ST_SCAN: begin
            state_in = sts.scan_end ? bhm_pkg::ST_ACT : bhm_pkg::ST_CMP;
         end
         bhm_pkg::ST_CMP: begin
            state_in = sts.key_match ? bhm_pkg::ST_ACT : bhm_pkg::ST_SCAN;
         end
         bhm_pkg::ST_ACT: begin
            if (sts.mode == bhm_pkg::MODE_REMOVE && sts.found && !sts.last_slot)
               state_in = bhm_pkg::ST_SHIFT_RD;
            else
               state_in = bhm_pkg::ST_RESP;
         end
         bhm_pkg::ST_SHIFT_RD: begin
            state_in = bhm_pkg::ST_SHIFT_WR;
         end
         bhm_pkg::ST_SHIFT_WR: begin
            state_in = sts.shift_last ? bhm_pkg::ST_RESP : bhm_pkg::ST_SHIFT_RD;
         end
         bhm_pkg::ST_RESP: begin
            if (sts.rsp_free) state_in = bhm_pkg::ST_IDLE;
         end
         default: begin
            state_in = bhm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != bhm_pkg::ST_IDLE);
      unique case (state_ff)
         bhm_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
         bhm_pkg::ST_IDLE:     cmd.accept   = req_valid;
         bhm_pkg::ST_MOD:      cmd.mod_step = 1'b1;
         bhm_pkg::ST_CNT:      cmd.cnt_rd   = 1'b1;
         bhm_pkg::ST_SCAN:     cmd.slot_rd  = !sts.scan_end;
         bhm_pkg::ST_CMP: begin
            cmd.set_found = sts.key_match;
            cmd.idx_inc   = !sts.key_match;
         end
         bhm_pkg::ST_ACT: begin
            case (sts.mode)
               bhm_pkg::MODE_PUT: begin
                  // hit overwrites in place; miss appends at index == count
                  if (sts.found) begin
                     cmd.put_wr = 1'b1;
                  end else if (!sts.full) begin
                     cmd.put_wr  = 1'b1;
                     cmd.cnt_wr  = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               bhm_pkg::MODE_REMOVE: begin
                  cmd.cnt_wr = sts.found;
               end
               default: begin
               end
            endcase
         end
         bhm_pkg::ST_SHIFT_RD: cmd.shift_rd = 1'b1;
         bhm_pkg::ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         bhm_pkg::ST_RESP:     cmd.rsp_load = sts.rsp_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/bucketed_hash_map_top.sv]
// Bucketed hash map: fixed-depth buckets of (key, value) slots.
// Request beat: req_mode (put, get, remove), req_key, req_value.
// Response beat: rsp_read_value, rsp_found, rsp_dropped; one per request.
// Bucket = key mod NUM_BUCKETS; each bucket keeps up to BUCKET_SLOTS pairs
// packed from slot 0. A put of a new key to a full bucket is dropped.
// Requests are handled one at a time; req_stall is low only while idle.
// Each request reads its bucket count, then compares slots in turn until
// a key matches or the count is reached; a remove then moves the later
// slots of the bucket down one place. When NUM_BUCKETS is not a power of
// two the bucket index comes from the digit-serial remainder unit.
// The response sits in an output register; a new request is accepted while
// it waits. A stalled response holds and blocks only the next response.
// After reset the bucket counts are cleared, one bucket per cycle, with
// req_stall high. Slot memories are not cleared.
// Depends on bhm_pkg, bhm_ctrl, bhm_dpath, bhm_mod.
module bucketed_hash_map_top #(
   parameter int NUM_BUCKETS  = bhm_pkg::DEF_NUM_BUCKETS,
   parameter int BUCKET_SLOTS = bhm_pkg::DEF_BUCKET_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bhm_pkg::MODE_W-1:0] req_mode,
   input  logic [bhm_pkg::KEY_W-1:0]  req_key,
   input  logic [bhm_pkg::VAL_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bhm_pkg::VAL_W-1:0]  rsp_read_value,
   output logic                       rsp_found,
   output logic                       rsp_dropped
);

   bhm_pkg::cmd_type cmd;
   bhm_pkg::sts_type sts;

   bhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bhm_dpath #(
      .NUM_BUCKETS  (NUM_BUCKETS),
      .BUCKET_SLOTS (BUCKET_SLOTS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_dropped    (rsp_dropped)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded over an untaken beat");

   a_put_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.put_wr |-> (sts.found || !sts.full))
      else $error("put written into a full bucket");

   a_single_slot_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.put_wr && cmd.shift_wr))
      else $error("two slot writes in one cycle");

endmodule
